// ===== rtl/pse_pkg.sv =====
// ----------------------------------------------------------------------------
// Position speed estimator package
// Shared widths, reset values and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int DEF_POS_WIDTH   = 32;
  localparam int DEF_STAMP_WIDTH = 32;
  localparam int TPM_W           = 16;
  localparam int SPEED_W         = 32;
  localparam logic [TPM_W-1:0] TPM_RESET = 16'd1000;

  typedef struct packed {
    logic       load;
    logic       sq;
    logic [1:0] sel;
    logic       root;
    logic       mul;
    logic       div;
    logic       out_load;
  } pse_cmd_t;

  typedef struct packed {
    logic zero_dt;
  } pse_stat_t;

endpackage

// ===== rtl/pse_ctrl.sv =====
// ----------------------------------------------------------------------------
// Position speed estimator controller
// Sequences squaring, square root, scaling and division; owns output valid.
// ----------------------------------------------------------------------------
module pse_ctrl
  import pse_pkg::*;
#(
  parameter int POS_WIDTH = DEF_POS_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output pse_cmd_t  cmd,
  input  pse_stat_t stat
);

  localparam int RT_W   = POS_WIDTH + 2;
  localparam int PROD_W = RT_W + TPM_W;
  localparam int CNT_W  = $clog2(PROD_W);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_ROOT = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.sel      = (cnt_r[1:0] == 2'd3) ? 2'd2 : cnt_r[1:0];
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SQ;
          cnt_nxt   = '0;
        end
      end
      S_SQ: begin
        cmd.sq  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(3)) begin
          cnt_nxt   = '0;
          state_nxt = stat.zero_dt ? S_DONE : S_ROOT;
        end
      end
      S_ROOT: begin
        cmd.root = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(RT_W - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(PROD_W - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_SQ) && (cnt_r == '0))
    else $error("accepted item did not start squaring");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result overwritten while still held");

  a_out_valid_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && (cnt_r == CNT_W'(PROD_W - 1)) |=> (state_r == S_DONE))
    else $error("division did not finish on its last step");

endmodule

// ===== rtl/pse_dpath.sv =====
// ----------------------------------------------------------------------------
// Position speed estimator datapath
// Differences, sum of squares, digit-by-digit root, scaling, restoring divide.
// ----------------------------------------------------------------------------
module pse_dpath
  import pse_pkg::*;
#(
  parameter int POS_WIDTH   = DEF_POS_WIDTH,
  parameter int STAMP_WIDTH = DEF_STAMP_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pse_cmd_t               cmd,
  output pse_stat_t              stat,
  input  logic [POS_WIDTH-1:0]   pos_x,
  input  logic [POS_WIDTH-1:0]   pos_y,
  input  logic [POS_WIDTH-1:0]   pos_z,
  input  logic [STAMP_WIDTH-1:0] stamp,
  input  logic                   cfg_we,
  input  logic [TPM_W-1:0]       cfg_data,
  output logic [SPEED_W-1:0]     speed,
  output logic                   zero_interval,
  output logic                   saturated
);

  localparam int MAG_W  = POS_WIDTH + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int RT_W   = MAG_W + 1;
  localparam int SUM_W  = 2 * RT_W;
  localparam int REM_W  = RT_W + 3;
  localparam int PROD_W = RT_W + TPM_W;
  localparam int QX_W   = (PROD_W > SPEED_W) ? PROD_W : SPEED_W + 1;

  logic [POS_WIDTH-1:0]   prev_r [3];
  logic [POS_WIDTH-1:0]   pos_in [3];
  logic [STAMP_WIDTH-1:0] prev_stamp_r;
  logic [TPM_W-1:0]       tpm_r;
  logic [MAG_W-1:0]       mag_r [3];
  logic [MAG_W-1:0]       mag_nxt [3];
  logic [MAG_W-1:0]       diff [3];
  logic [STAMP_WIDTH-1:0] dt_r;
  logic                   zero_dt_r;
  logic [SQ_W-1:0]        p_r;
  logic [SUM_W-1:0]       sum_r;
  logic [RT_W-1:0]        root_r;
  logic [REM_W-1:0]       rem_r;
  logic [REM_W-1:0]       rem_sh;
  logic [REM_W-1:0]       trial;
  logic [PROD_W-1:0]      prod_r;
  logic [STAMP_WIDTH-1:0] drem_r;
  logic [STAMP_WIDTH:0]   drem_sh;
  logic                   qbit;
  logic [QX_W-1:0]        qx;
  logic                   sat_c;
  logic [SPEED_W-1:0]     speed_r;
  logic                   zero_r;
  logic                   sat_r;

  assign pos_in[0] = pos_x;
  assign pos_in[1] = pos_y;
  assign pos_in[2] = pos_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]    = {pos_in[i][POS_WIDTH-1], pos_in[i]} - {prev_r[i][POS_WIDTH-1], prev_r[i]};
      mag_nxt[i] = diff[i][MAG_W-1] ? (~diff[i] + 1'b1) : diff[i];
    end
  end

  assign stat.zero_dt = zero_dt_r;

  assign rem_sh  = {rem_r[RT_W:0], sum_r[SUM_W-1 -: 2]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign drem_sh = {drem_r, prod_r[PROD_W-1]};
  assign qbit    = (drem_sh >= {1'b0, dt_r});
  assign qx      = QX_W'(prod_r);
  assign sat_c   = |qx[QX_W-1:SPEED_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        prev_r[i] <= '0;
      end
      prev_stamp_r <= '0;
      tpm_r        <= TPM_RESET;
    end else begin
      if (cfg_we) begin
        tpm_r <= cfg_data;
      end
      if (cmd.load) begin
        for (int i = 0; i < 3; i++) begin
          prev_r[i] <= pos_in[i];
        end
        prev_stamp_r <= stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 3; i++) begin
        mag_r[i] <= mag_nxt[i];
      end
      dt_r      <= stamp - prev_stamp_r;
      zero_dt_r <= (stamp == prev_stamp_r);
      p_r       <= '0;
      sum_r     <= '0;
      root_r    <= '0;
      rem_r     <= '0;
    end
    if (cmd.sq) begin
      p_r   <= mag_r[cmd.sel] * mag_r[cmd.sel];
      sum_r <= sum_r + SUM_W'(p_r);
    end
    if (cmd.root) begin
      sum_r <= {sum_r[SUM_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[RT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[RT_W-2:0], 1'b0};
      end
    end
    if (cmd.mul) begin
      prod_r <= {{TPM_W{1'b0}}, root_r} * {{RT_W{1'b0}}, tpm_r};
      drem_r <= '0;
    end
    if (cmd.div) begin
      drem_r <= qbit ? STAMP_WIDTH'(drem_sh - {1'b0, dt_r}) : drem_sh[STAMP_WIDTH-1:0];
      prod_r <= {prod_r[PROD_W-2:0], qbit};
    end
    if (cmd.out_load) begin
      zero_r <= zero_dt_r;
      if (zero_dt_r) begin
        speed_r <= '0;
        sat_r   <= 1'b0;
      end else begin
        speed_r <= sat_c ? '1 : qx[SPEED_W-1:0];
        sat_r   <= sat_c;
      end
    end
  end

  assign speed         = speed_r;
  assign zero_interval = zero_r;
  assign saturated     = sat_r;

endmodule

// ===== rtl/position_speed_estimator_top.sv =====
// ----------------------------------------------------------------------------
// Position speed estimator
// Speed from successive timestamped 3D positions.
//
// Input stream in_*: one item per position sample, tdata packs pos_x, pos_y,
// pos_z (signed Q16.16) and stamp (tick count). Output stream out_*: one item
// per sample, tdata is speed (unsigned Q16.16 per millisecond), tuser carries
// the zero_interval and saturated flags. cfg_* writes ticks_per_ms; write it
// only while the block is idle.
// Each item is squared on one multiplier, then takes one root digit per cycle,
// one scaling multiply and one quotient bit per cycle before a valid result.
// The next item is taken once the result is loaded; a zero tick interval
// skips root, scaling and divide. A single output register holds the result,
// so the next item is accepted while it waits; if the receiver stalls, the
// following result waits in the controller until the register frees.
// Reset clears the stored position and stamp to zero, ticks_per_ms to 1000.
// ----------------------------------------------------------------------------
module position_speed_estimator_top
  import pse_pkg::*;
#(
  parameter int POS_WIDTH   = DEF_POS_WIDTH,
  parameter int STAMP_WIDTH = DEF_STAMP_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // pos_x, pos_y, pos_z, stamp, zero padding
  input  logic [((3*POS_WIDTH+STAMP_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // speed
  output logic [SPEED_W-1:0]   out_tdata,
  // zero_interval, saturated
  output logic [1:0]           out_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [TPM_W-1:0]     cfg_data
);

  pse_cmd_t  cmd;
  pse_stat_t stat;
  logic      zero_interval;
  logic      saturated;

  assign cfg_ready = 1'b1;
  assign out_tuser = {saturated, zero_interval};

  pse_ctrl #(
    .POS_WIDTH(POS_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  pse_dpath #(
    .POS_WIDTH  (POS_WIDTH),
    .STAMP_WIDTH(STAMP_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .pos_x        (in_tdata[POS_WIDTH-1:0]),
    .pos_y        (in_tdata[2*POS_WIDTH-1:POS_WIDTH]),
    .pos_z        (in_tdata[3*POS_WIDTH-1:2*POS_WIDTH]),
    .stamp        (in_tdata[3*POS_WIDTH+STAMP_WIDTH-1:3*POS_WIDTH]),
    .cfg_we       (cfg_valid),
    .cfg_data     (cfg_data),
    .speed        (out_tdata),
    .zero_interval(zero_interval),
    .saturated    (saturated)
  );

endmodule

// ===== sim/speed_checker.sv =====
// ----------------------------------------------------------------------------
// Speed checker
// Watches the sample, result and ticks_per_ms channels of the position speed
// estimator, works out the speed owed for every accepted sample from its own
// copy of the stored position, stamp and scale, and compares each result,
// field by field, with the oldest speed still owed.
// ----------------------------------------------------------------------------
module speed_checker
  import pse_pkg::*;
#(
  parameter int IN_W = ((3*DEF_POS_WIDTH+DEF_STAMP_WIDTH+7)/8)*8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [IN_W-1:0]    in_tdata,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [SPEED_W-1:0] out_tdata,
  input  logic [1:0]         out_tuser,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [TPM_W-1:0]   cfg_data,
  output int                 n_pending,
  output int                 n_errors,
  output int                 n_checked,
  output int                 n_zero,
  output int                 n_sat
);

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic               zero_interval;
    logic               saturated;
  } speed_result_t;

  logic [31:0]      last_pos [3];
  logic [31:0]      last_stamp;
  logic [TPM_W-1:0] tpm;
  speed_result_t    speeds_due [$];
  int               err_cnt = 0;
  int               chk_cnt = 0;
  int               zero_cnt = 0;
  int               sat_cnt = 0;

  function automatic speed_result_t estimate_speed(input logic [31:0] pos [3],
                                                   input logic [31:0] stamp);
    speed_result_t     res;
    logic signed [33:0] diff;
    logic [67:0]       mag;
    logic [67:0]       dist_sq;
    logic [67:0]       root;
    logic [67:0]       trial;
    logic [67:0]       scaled;
    logic [67:0]       quot;
    logic [67:0]       interval;
    res      = '0;
    dist_sq  = '0;
    root     = '0;
    interval = {36'd0, stamp - last_stamp};
    for (int i = 0; i < 3; i++) begin
      diff = $signed({pos[i][31], pos[i]}) - $signed({last_pos[i][31], last_pos[i]});
      mag = (diff < 0) ? 68'(-diff) : 68'(diff);
      dist_sq = dist_sq + mag * mag;
    end
    if (interval == 0) begin
      res.zero_interval = 1'b1;
    end else begin
      for (int b = 33; b >= 0; b--) begin
        trial = root | (68'd1 << b);
        if (trial * trial <= dist_sq) root = trial;
      end
      scaled = root * {52'd0, tpm};
      quot = scaled / interval;
      if (quot > 68'hFFFF_FFFF) begin
        res.speed     = '1;
        res.saturated = 1'b1;
      end else begin
        res.speed = quot[31:0];
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    speed_result_t want;
    speed_result_t got;
    logic [31:0]   pos [3];
    if (!rst_n) begin
      last_pos[0] = '0;
      last_pos[1] = '0;
      last_pos[2] = '0;
      last_stamp  = '0;
      tpm         = TPM_RESET;
      speeds_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) tpm = cfg_data;
      if (out_tvalid && out_tready) begin
        got.speed         = out_tdata;
        got.zero_interval = out_tuser[0];
        got.saturated     = out_tuser[1];
        if (speeds_due.size() == 0) begin
          $error("speed: result %h with nothing expected", got.speed);
          err_cnt++;
        end else begin
          want = speeds_due.pop_front();
          chk_cnt++;
          if (got.speed !== want.speed) begin
            $error("speed: expected %h, got %h", want.speed, got.speed);
            err_cnt++;
          end
          if (got.zero_interval !== want.zero_interval) begin
            $error("zero_interval: expected %b, got %b", want.zero_interval,
                   got.zero_interval);
            err_cnt++;
          end
          if (got.saturated !== want.saturated) begin
            $error("saturated: expected %b, got %b", want.saturated, got.saturated);
            err_cnt++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        pos[0] = in_tdata[31:0];
        pos[1] = in_tdata[63:32];
        pos[2] = in_tdata[95:64];
        want = estimate_speed(pos, in_tdata[127:96]);
        if (want.zero_interval) zero_cnt++;
        if (want.saturated) sat_cnt++;
        speeds_due.push_back(want);
        last_pos   = pos;
        last_stamp = in_tdata[127:96];
      end
    end
    n_pending <= speeds_due.size();
    n_errors  <= err_cnt;
    n_checked <= chk_cnt;
    n_zero    <= zero_cnt;
    n_sat     <= sat_cnt;
  end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Position speed estimator testbench
// Drives timestamped position samples and ticks_per_ms writes into the block,
// first a directed set of corner cases, then phases of random trajectories,
// jumps, repeated and wrapping stamps under varying sender idling and
// receiver stalls. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import pse_pkg::*;

  localparam int IN_W        = ((3*DEF_POS_WIDTH+DEF_STAMP_WIDTH+7)/8)*8;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 160;
  localparam int HOLD_CYCLES = 1000;
  localparam int TAIL        = 200;
  localparam int LIMIT       = 2000000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  // pos_x, pos_y, pos_z, stamp
  logic [IN_W-1:0]    in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  // speed
  logic [SPEED_W-1:0] out_tdata;
  // zero_interval, saturated
  logic [1:0]         out_tuser;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [TPM_W-1:0]   cfg_data = '0;

  int          n_pending;
  int          n_errors;
  int          n_checked;
  int          n_zero;
  int          n_sat;
  int          items_sent = 0;
  int unsigned in_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_go = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;
  logic [31:0] last_x = '0;
  logic [31:0] last_y = '0;
  logic [31:0] last_z = '0;
  logic [31:0] last_st = '0;

  always #1 clk = ~clk;

  position_speed_estimator_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  speed_checker #(.IN_W(IN_W)) chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .n_pending  (n_pending),
    .n_errors   (n_errors),
    .n_checked  (n_checked),
    .n_zero     (n_zero),
    .n_sat      (n_sat)
  );

  // hold off for a long stretch on request, otherwise stall at random
  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen  <= hold_go;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(99) < stall_pct) begin
      out_tready <= 1'b0;
      if ($urandom_range(15) == 0) hold_left <= $urandom_range(1, 100);
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic logic [IN_W-1:0] pack_sample(input logic [31:0] x, y, z, st);
    return {st, z, y, x};
  endfunction

  function automatic logic [31:0] nudge(input logic [31:0] v, input int unsigned span);
    return v + $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic logic [31:0] extreme_coord();
    case ($urandom_range(3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [IN_W-1:0] random_sample();
    int unsigned pick;
    int unsigned span;
    logic [31:0] x, y, z, st;
    pick = $urandom_range(99);
    span = 32'd1 << (8 * $urandom_range(0, 3));
    x = nudge(last_x, span);
    y = nudge(last_y, span);
    z = nudge(last_z, span);
    st = last_st + $urandom_range(1, 5000);
    if (pick >= 45 && pick < 55) begin
      st = last_st;
    end else if (pick >= 55 && pick < 75) begin
      x = $urandom;
      y = $urandom;
      z = $urandom;
      st = $urandom;
    end else if (pick >= 75 && pick < 88) begin
      x = extreme_coord();
      y = extreme_coord();
      z = extreme_coord();
      st = last_st + $urandom_range(0, 3);
    end else if (pick >= 88) begin
      if ($urandom_range(1) == 0) st = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      else st = last_st - $urandom_range(1, 3000);
    end
    return pack_sample(x, y, z, st);
  endfunction

  task automatic send_item(input logic [IN_W-1:0] item);
    in_tdata  <= item;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    last_x  = item[31:0];
    last_y  = item[63:32];
    last_z  = item[95:64];
    last_st = item[127:96];
    if ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 120)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
  endtask

  task automatic write_tpm(input logic [TPM_W-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb: errors");
    $finish;
  end

  initial begin : stimulus
    int unsigned mode;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(pack_sample(32'h0, 32'h0, 32'h0, 32'h0));
    send_item(pack_sample(32'h0001_0000, 32'h0, 32'h0, 32'd1000));
    send_item(pack_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1001));
    send_item(pack_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd1002));
    send_item(pack_sample(32'h0, 32'h0, 32'h0, 32'd1002));
    send_item(pack_sample(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF));
    send_item(pack_sample(32'h0003_0000, 32'h0004_0000, 32'h0, 32'd5));
    send_item(pack_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd6));
    send_item(pack_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h8000_0006));
    send_item(pack_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0005));
    drain();
    write_tpm(16'd1);
    send_item(pack_sample(32'h8000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0006));
    send_item(pack_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0007));
    send_item(pack_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0007));
    drain();
    write_tpm(16'hFFFF);
    send_item(pack_sample(32'h0000_0001, 32'h0, 32'h0, 32'h8000_0008));
    send_item(pack_sample(32'h0100_0000, 32'h0, 32'h0, 32'h8000_0009));
    send_item(pack_sample(32'h0100_0001, 32'h0, 32'h0, 32'h7FFF_FFFF));
    drain();
    write_tpm(16'd0);
    send_item(pack_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    send_item(pack_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));

    for (int ph = 0; ph < PHASES; ph++) begin
      mode = ph % 4;
      drain();
      case (mode)
        0:       write_tpm(ph < 4 ? 16'hFFFF : 16'($urandom_range(1, 65535)));
        1:       write_tpm(ph < 4 ? 16'd1 : 16'($urandom_range(1, 300)));
        2:       write_tpm(16'($urandom_range(1, 65535)));
        default: write_tpm(TPM_RESET);
      endcase
      in_idle_pct = (mode == 1) ? 46 : (mode == 3) ? 21 : 0;
      stall_pct  <= (mode == 2) ? 46 : (mode == 3) ? 21 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == 40) hold_go <= ~hold_go;
        if (ph == 2 && n == 80) drain();
        send_item(random_sample());
      end
    end

    drain();
    repeat (TAIL) @(posedge clk);
    $display("summary: %0d samples sent, %0d results checked, %0d zero intervals, %0d saturated",
             items_sent, n_checked, n_zero, n_sat);
    $display("summary: ticks_per_ms 0, 1, 1000, 65535 and random; idle, stall and hold-off phases");
    if (n_errors == 0 && n_pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
